// ===== hw/rtl/kpq_pkg.sv =====
// kpq_pkg: shared types and constants of the k-point plus q mesh mapper
// no dependencies; used by kpq_mesh_mem, kpq_dist_unit and the top level
package kpq_pkg;

	// Q8.24 fixed point
	localparam logic [24:0] ONE_Q  = 25'h100_0000;
	localparam logic [23:0] HALF_Q = 24'h80_0000;

	// request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_START = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NO_TARGET = 3'd2;
	localparam logic [2:0] ST_DUPLICATE = 3'd3;
	localparam logic [2:0] ST_BAD_SHIFT = 3'd4;

	// register indexes
	localparam logic [1:0] CFG_Q_X = 2'd0;
	localparam logic [1:0] CFG_Q_Y = 2'd1;
	localparam logic [1:0] CFG_Q_Z = 2'd2;
	localparam logic [1:0] CFG_TOL = 2'd3;

	localparam logic [23:0] TOL_RESET = 24'd16;

	// one mesh point, lane 0 is x
	typedef logic [2:0][31:0] point_t;
	// k + q per axis, 33 bit signed
	typedef logic [2:0][32:0] kq_vec_t;

	// per-axis answer of the distance unit
	typedef struct packed {
		logic       fit;  // distance to nearest integer within tolerance
		logic [9:0] rnd;  // rounded integer, low 10 bits
	} lane_res_t;

	typedef lane_res_t [2:0] lane_res_vec_t;

endpackage

// ===== hw/rtl/kpq_mesh_mem.sv =====
// kpq_mesh_mem: mesh point store, one write port and one registered read port
// depends on kpq_pkg for the point type
module kpq_mesh_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  kpq_pkg::point_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output kpq_pkg::point_t rd_data
);
	import kpq_pkg::*;

	point_t mem [DEPTH];
	point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/kpq_dist_unit.sv =====
// kpq_dist_unit: shared difference, round-to-nearest and tolerance unit, three axes
// depends on kpq_pkg; used for both the mesh scan and the shift check
module kpq_dist_unit (
	input  kpq_pkg::kq_vec_t      kq,
	input  kpq_pkg::point_t       pt,
	input  logic [23:0]           tol,
	output kpq_pkg::lane_res_vec_t res
);
	import kpq_pkg::*;

	for (genvar a = 0; a < 3; a++) begin : g_lane
		logic [33:0] diff;
		logic [23:0] frac;
		logic [24:0] comp;
		logic [23:0] resid;
		logic [33:0] rsum;

		assign diff = {kq[a][32], kq[a]} - {{2{pt[a][31]}}, pt[a]};
		// distance to nearest integer is min(frac, one - frac), sign does not matter
		assign frac  = diff[23:0];
		assign comp  = ONE_Q - {1'b0, frac};
		assign resid = frac[23] ? comp[23:0] : frac;
		// half away from zero: negative values add one less
		assign rsum  = diff + {10'd0, HALF_Q} - {33'd0, diff[33]};

		assign res[a].fit = (resid <= tol);
		assign res[a].rnd = rsum[33:24];
	end

endmodule

// ===== hw/rtl/kpoint_plus_q_mesh_mapper.sv =====
// kpoint_plus_q_mesh_mapper: top level, sequencer, registers and result port
// depends on kpq_pkg, kpq_mesh_mem and kpq_dist_unit
//
// The block keeps a mesh of up to MESH_POINTS k-points (Q8.24) and maps
// k + q back onto the mesh. A beat with req_type load stores one point
// (busy stays low); the first load after a start opens a new mesh, and loads
// past a full mesh are dropped. A start beat maps every stored point in order:
// it forms k + q, scans all stored points for the one whose periodic
// max-norm distance is within match_tolerance, reads that target back and
// checks that the reciprocal shift round(k + q - target) is integral within
// tolerance. For a mesh of n points each mapped point passes through source
// read, sum, n candidate reads through the single store read port, target
// read and shift check; busy is high throughout and no beat is taken.
// Results come out as one-cycle strobes on result_valid and the receiver
// cannot stall them. An empty mesh, no match, a second match or a non-integral
// shift gives one error beat that ends the run with last_of_run set and zero
// target and shift fields. Configuration is always ready and must be written
// only while the block is idle. The store has no clearing pass; only entries
// below the point count are ever used.
module kpoint_plus_q_mesh_mapper #(
	parameter int MESH_POINTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [31:0] k_x,
	input  logic [31:0] k_y,
	input  logic [31:0] k_z,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// results
	output logic        result_valid,
	output logic [2:0]  status,
	output logic [5:0]  src_index,
	output logic [5:0]  tgt_index,
	output logic [31:0] target_x,
	output logic [31:0] target_y,
	output logic [31:0] target_z,
	output logic [9:0]  shift_x,
	output logic [9:0]  shift_y,
	output logic [9:0]  shift_z,
	output logic        last_of_run
);
	import kpq_pkg::*;

	localparam int IDX_W = (MESH_POINTS > 1) ? $clog2(MESH_POINTS) : 1;
	localparam int CNT_W = $clog2(MESH_POINTS + 1);

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SRC_RD  = 3'd1;  // read source point
	localparam logic [2:0] S_SRC_KQ  = 3'd2;  // form k + q, issue first candidate
	localparam logic [2:0] S_SCAN    = 3'd3;  // one candidate per cycle
	localparam logic [2:0] S_TGT_RD  = 3'd4;  // read matched target
	localparam logic [2:0] S_TGT_CHK = 3'd5;  // shift check and result

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic             restart_q;
	logic [IDX_W-1:0] src_q;
	logic [IDX_W-1:0] chk_q;
	logic [IDX_W-1:0] tgt_q;
	logic             found_q;
	logic [31:0]      q_x_q;
	logic [31:0]      q_y_q;
	logic [31:0]      q_z_q;
	logic [23:0]      tol_q;
	kq_vec_t          kq_q;

	logic             result_valid_q;
	logic [2:0]       status_q;
	logic [5:0]       src_out_q;
	logic [5:0]       tgt_out_q;
	point_t           tc_out_q;
	logic [2:0][9:0]  sh_out_q;
	logic             last_q;

	// store ports
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	point_t           wr_data;
	logic [IDX_W-1:0] rd_addr;
	point_t           rd_data;
	lane_res_vec_t    res;

	logic             load_acc;
	logic             start_acc;
	logic [CNT_W-1:0] eff_cnt;
	logic             hit;
	logic             bad;
	logic             scan_end;
	logic             src_last;
	logic             emit;
	logic             emit_ok;
	logic [2:0]       emit_status;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign load_acc  = start && !busy && (req_type == REQ_LOAD);
	assign start_acc = start && !busy && (req_type == REQ_START);

	// a load after a start begins a new mesh
	assign eff_cnt = restart_q ? '0 : count_q;
	assign wr_en   = load_acc && (eff_cnt < CNT_W'(MESH_POINTS));
	assign wr_addr = eff_cnt[IDX_W-1:0];
	assign wr_data = {k_z, k_y, k_x};

	always_comb begin
		case (state_q)
			S_SRC_RD: rd_addr = src_q;
			S_SCAN:   rd_addr = chk_q + IDX_W'(1);  // prefetch next candidate
			S_TGT_RD: rd_addr = tgt_q;
			default:  rd_addr = '0;
		endcase
	end

	kpq_mesh_mem #(
		.DEPTH (MESH_POINTS),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// the folded point is congruent to k + q modulo one, and the periodic
	// distance only looks at the fraction, so the scan runs on k + q directly
	kpq_dist_unit u_dist (
		.kq  (kq_q),
		.pt  (rd_data),
		.tol (tol_q),
		.res (res)
	);

	assign hit      = res[0].fit && res[1].fit && res[2].fit;
	assign bad      = !hit;
	assign scan_end = (CNT_W'(chk_q) + CNT_W'(1)) == count_q;
	assign src_last = (CNT_W'(src_q) + CNT_W'(1)) == count_q;

	// result selection
	always_comb begin
		emit        = 1'b0;
		emit_ok     = 1'b0;
		emit_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start_acc && (count_q == '0)) begin
					emit        = 1'b1;
					emit_status = ST_EMPTY;
				end
			end
			S_SCAN: begin
				if (hit && found_q) begin
					emit        = 1'b1;
					emit_status = ST_DUPLICATE;
				end else if (scan_end && !hit && !found_q) begin
					emit        = 1'b1;
					emit_status = ST_NO_TARGET;
				end
			end
			S_TGT_CHK: begin
				emit        = 1'b1;
				emit_ok     = !bad;
				emit_status = bad ? ST_BAD_SHIFT : ST_OK;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// control and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			restart_q      <= 1'b0;
			src_q          <= '0;
			chk_q          <= '0;
			tgt_q          <= '0;
			found_q        <= 1'b0;
			q_x_q          <= '0;
			q_y_q          <= '0;
			q_z_q          <= '0;
			tol_q          <= TOL_RESET;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= emit;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_Q_X: q_x_q <= cfg_data;
					CFG_Q_Y: q_y_q <= cfg_data;
					CFG_Q_Z: q_z_q <= cfg_data;
					CFG_TOL: tol_q <= cfg_data[23:0];
					default: tol_q <= tol_q;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (load_acc) begin
						restart_q <= 1'b0;
						count_q   <= wr_en ? eff_cnt + CNT_W'(1) : eff_cnt;
					end else if (start_acc) begin
						restart_q <= 1'b1;
						src_q     <= '0;
						if (count_q != '0) begin
							state_q <= S_SRC_RD;
						end
					end
				end
				S_SRC_RD: begin
					state_q <= S_SRC_KQ;
				end
				S_SRC_KQ: begin
					chk_q   <= '0;
					found_q <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (hit && found_q) begin
						state_q <= S_IDLE;
					end else begin
						if (hit) begin
							found_q <= 1'b1;
							tgt_q   <= chk_q;
						end
						if (scan_end) begin
							state_q <= (hit || found_q) ? S_TGT_RD : S_IDLE;
						end else begin
							chk_q <= chk_q + IDX_W'(1);
						end
					end
				end
				S_TGT_RD: begin
					state_q <= S_TGT_CHK;
				end
				S_TGT_CHK: begin
					if (bad || src_last) begin
						state_q <= S_IDLE;
					end else begin
						src_q   <= src_q + IDX_W'(1);
						state_q <= S_SRC_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: k + q and the result beat
	always_ff @(posedge clk) begin
		if (state_q == S_SRC_KQ) begin
			kq_q[0] <= {rd_data[0][31], rd_data[0]} + {q_x_q[31], q_x_q};
			kq_q[1] <= {rd_data[1][31], rd_data[1]} + {q_y_q[31], q_y_q};
			kq_q[2] <= {rd_data[2][31], rd_data[2]} + {q_z_q[31], q_z_q};
		end
		if (emit) begin
			status_q  <= emit_status;
			src_out_q <= (state_q == S_IDLE) ? 6'd0 : 6'(src_q);
			tgt_out_q <= emit_ok ? 6'(tgt_q) : 6'd0;
			tc_out_q  <= emit_ok ? rd_data : '0;
			sh_out_q  <= emit_ok ? {res[2].rnd, res[1].rnd, res[0].rnd} : '0;
			last_q    <= !emit_ok || src_last;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign src_index    = src_out_q;
	assign tgt_index    = tgt_out_q;
	assign target_x     = tc_out_q[0];
	assign target_y     = tc_out_q[1];
	assign target_z     = tc_out_q[2];
	assign shift_x      = sh_out_q[0];
	assign shift_y      = sh_out_q[1];
	assign shift_z      = sh_out_q[2];
	assign last_of_run  = last_q;

`ifndef SYNTH
	// an error beat always closes the run
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> last_of_run)
		else $error("error result without last_of_run");

	// error beats carry no target or shift
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |->
		(tgt_index == 6'd0) && (shift_x == 10'd0) && (target_x == 32'd0))
		else $error("error result with nonzero target fields");

	// the last beat of a run leaves the block idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_run |-> !busy)
		else $error("busy after last result");

	// a run only begins on an accepted start
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) && ($past(req_type) == REQ_START))
		else $error("busy without start");

	// an empty mesh result comes only from source zero
	a_empty_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_EMPTY) |-> (src_index == 6'd0) && !busy)
		else $error("empty mesh result out of place");
`endif

endmodule
